[hdl/lru_page_replacement_assert.svh]
// Assertion macros used by the checker file.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define LRUPR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("lru_page_replacement: assertion failed");

// Check a property on every clock edge, reset included.
`define LRUPR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("lru_page_replacement: assertion failed");

`endif

[hdl/lrupr_pkg.sv]
// Package: sizes, status codes and controller/datapath links of the LRU page unit.
`default_nettype none
package lrupr_pkg;
    localparam int FRAME_COUNT = 8;
    localparam int PAGE_COUNT  = 64;
    localparam int FRAME_W     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
    localparam int PAGE_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int OUT_FRAME_W = 3;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 16;

    localparam logic [STATUS_W-1:0] ST_HIT   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EVICT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE  = 2'd3;

    typedef struct packed {
        logic latch;   // capture the requested page
        logic look;    // search frames and recency list
        logic commit;  // update state and load the result
    } t_cmd;

    typedef struct packed {
        logic out_free;  // result register can take a beat
    } t_sts;
endpackage
`default_nettype wire

[hdl/lrupr_ctrl.sv]
// Controller: sequences latch, lookup and commit for one request at a time.
`default_nettype none
module lrupr_ctrl
    import lrupr_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_COMMIT} t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

[hdl/lrupr_dp.sv]
// Datapath: frame table, recency list, lookup results and output register.
`default_nettype none
module lrupr_dp
    import lrupr_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  wire  [PAGE_W-1:0]     i_page,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);
    logic [FRAME_COUNT-1:0] r_occ;
    logic [PAGE_W-1:0]      r_owner [FRAME_COUNT];
    logic [PAGE_W-1:0]      r_rec   [FRAME_COUNT];
    logic [CNT_W-1:0]       r_cnt;
    logic [PAGE_W-1:0]      r_page;

    logic [STATUS_W-1:0]    r_status;
    logic [FRAME_W-1:0]     r_frame;
    logic [PAGE_W-1:0]      r_evp;
    logic                   r_drop, r_map, r_app;
    logic [FRAME_W-1:0]     r_pos;

    logic                   r_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data;

    logic                   hit, free, in_list;
    logic [FRAME_W-1:0]     hit_frame, free_frame, vic_frame, pos;
    logic [CNT_W-1:0]       cnt_mid;

    always_comb begin
        hit = 1'b0; free = 1'b0; in_list = 1'b0;
        hit_frame = '0; free_frame = '0; vic_frame = '0; pos = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (r_occ[i] && r_owner[i] == r_page) begin
                hit       = 1'b1;
                hit_frame = FRAME_W'(i);
            end
            if (!r_occ[i] && !free) begin
                free       = 1'b1;
                free_frame = FRAME_W'(i);
            end
            if (r_occ[i] && r_owner[i] == r_rec[0]) begin
                vic_frame = FRAME_W'(i);
            end
            if (!in_list && CNT_W'(i) < r_cnt && r_rec[i] == r_page) begin
                in_list = 1'b1;
                pos     = FRAME_W'(i);
            end
        end
    end

    assign cnt_mid = r_cnt - CNT_W'(r_drop);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_page <= i_page;
        end
        if (i_cmd.look) begin
            r_evp  <= '0;
            r_pos  <= '0;
            r_drop <= 1'b0;
            r_map  <= 1'b0;
            r_app  <= 1'b1;
            priority if (hit) begin
                r_status <= ST_HIT;
                r_frame  <= hit_frame;
                r_drop   <= in_list;
                r_pos    <= pos;
            end else if (free) begin
                r_status <= ST_LOAD;
                r_frame  <= free_frame;
                r_map    <= 1'b1;
            end else if (r_cnt == '0) begin
                r_status <= ST_NONE;
                r_frame  <= '0;
                r_app    <= 1'b0;
            end else begin
                r_status <= ST_EVICT;
                r_frame  <= vic_frame;
                r_evp    <= r_rec[0];
                r_drop   <= 1'b1;
                r_map    <= 1'b1;
            end
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < FRAME_COUNT; i++) begin
                if (r_app && CNT_W'(i) == cnt_mid) begin
                    r_rec[i] <= r_page;
                end else if (i < FRAME_COUNT - 1 && r_drop && FRAME_W'(i) >= r_pos
                             && CNT_W'(i + 1) < r_cnt) begin
                    r_rec[i] <= r_rec[(i + 1) % FRAME_COUNT];
                end
            end
            if (r_map) begin
                r_owner[r_frame] <= r_page;
            end
            r_out_data <= {{(OUT_DATA_W - 2*PAGE_W)-STATUS_W+2{1'b0}}, r_evp,
                           r_status == ST_EVICT, OUT_FRAME_W'(r_frame), r_status};
        end
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (r_map) begin
                    r_occ[r_frame] <= 1'b1;
                end
                if (r_app && cnt_mid < CNT_W'(FRAME_COUNT)) begin
                    r_cnt <= cnt_mid + CNT_W'(1);
                end else begin
                    r_cnt <= cnt_mid;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;
endmodule
`default_nettype wire

[hdl/lru_page_replacement.sv]
// Top level of the LRU page replacement unit.
// Use: one page request enters as a beat on the s_axis channel: s_axis_tdata[5:0]
// holds the page number. Each request yields exactly one result beat on m_axis:
// status, frame holding the page, evicted flag and evicted page.
// Status: hit, loaded into the lowest free frame, loaded after evicting the least
// recently used page, or no victim found.
// Each request beat is latched, then passes the lookup state and the commit state;
// the result beat is registered at commit and then waits in the output register.
// The controller takes one request at a time; the lookup and the recency update
// each take a state of their own, since every request depends on the state the
// previous one left behind.
// The next request is taken while a result still waits in the output register;
// its commit holds until that register is free, so a stalled receiver backs up
// into s_axis_tready after at most one further request.
// Reset (synchronous, active low) empties all frames and the recency list and
// drops any pending result beat.
`default_nettype none
module lru_page_replacement
    import lrupr_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,   // [5:0] page_number
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // [1:0] status, [4:2] frame_number, [5] evicted_valid, [11:6] evicted_page
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);
    t_cmd cmd;
    t_sts sts;

    // Sequence each request through lookup and commit.
    lrupr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold the frame table, recency list and result register.
    lrupr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_page      (s_axis_tdata[PAGE_W-1:0]),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );
endmodule
`default_nettype wire

[hdl/lru_page_replacement_chk.sv]
// Port checker for the LRU page replacement unit, bound to the top level.
`default_nettype none
`include "lru_page_replacement_assert.svh"
module lru_page_replacement_chk
    import lrupr_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [7:0]  s_axis_tdata,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);
    wire [STATUS_W-1:0] out_status = m_axis_tdata[1:0];
    wire                out_ev     = m_axis_tdata[5];
    wire [PAGE_W-1:0]   out_evp    = m_axis_tdata[11:6];

    `LRUPR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    `LRUPR_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    `LRUPR_ASSERT(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    `LRUPR_ASSERT(a_evict_flag, m_axis_tvalid |-> (out_ev == (out_status == ST_EVICT)))
    `LRUPR_ASSERT_ALWAYS(a_no_evict_page, m_axis_tvalid && !out_ev |-> out_evp == '0)
endmodule

bind lru_page_replacement lru_page_replacement_chk u_chk (.*);
`default_nettype wire
